// ----- hw/rtl/mva_pkg.sv -----
// mva_pkg: shared constants, opcodes and beat types for the voice allocator
// depends on nothing; used by midi_voice_allocator
package mva_pkg;

  localparam int NUM_VOICES      = 16;
  localparam int NUM_CHANNELS    = 16;
  localparam int PEDAL_THRESHOLD = 64;
  localparam int VOICE_W         = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W           = $clog2(NUM_VOICES + 1);
  localparam int AGE_W           = 32;
  localparam int CH_IDX_W        = $clog2(NUM_CHANNELS);

  typedef enum logic [2:0] {
    OP_NOTE_ON     = 3'd0,
    OP_NOTE_OFF    = 3'd1,
    OP_SUSTAIN     = 3'd2,
    OP_SOUND_OFF   = 3'd3,
    OP_NOTES_OFF   = 3'd4,
    OP_RESET_CTRL  = 3'd5,
    OP_VOICE_DONE  = 3'd6
  } opcode_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] channel;
    logic [6:0] note;
    logic       sample_present;
    logic [6:0] pedal_value;
    logic [3:0] finished_voice;
  } cmd_t;

  typedef struct packed {
    logic       allocated;
    logic [3:0] voice_index;
    logic       stole_voice;
    logic [4:0] active_count;
  } result_t;

  // one voice table entry as held in the memory
  typedef struct packed {
    logic             busy;
    logic [6:0]       note;
    logic [4:0]       channel;
    logic             held;
    logic             releasing;
    logic [AGE_W-1:0] age;
  } voice_t;

endpackage

// ----- hw/rtl/midi_voice_allocator.sv -----
// midi_voice_allocator: polyphonic voice table with oldest-voice stealing, depends on mva_pkg
// voice table lives in a one-read one-write synchronous memory, scanned once per event
// each event runs one scan of the table and, for a note on that takes a voice, a commit
// state after it; busy drops as done rises, so the next beat is taken at the edge
// that ends done; a new event is taken only after the last one has reported
// reset clears voices via valid bits, pedal flags and age clock directly; no result stall
module midi_voice_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mva_pkg::cmd_t    cmd,
  output logic             done,
  output mva_pkg::result_t result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t                       state;
  mva_pkg::cmd_t                cmd_q;
  logic                         ch_ok;
  logic                         pedal_cur;
  logic [mva_pkg::CNT_W-1:0]    rd_cnt;
  logic                         proc_vld;
  logic [mva_pkg::VOICE_W-1:0]  proc_idx;
  logic                         free_found;
  logic [mva_pkg::VOICE_W-1:0]  free_idx;
  logic [mva_pkg::AGE_W-1:0]    min_age;
  logic [mva_pkg::VOICE_W-1:0]  min_idx;
  logic [mva_pkg::CNT_W-1:0]    busy_cnt;
  logic [mva_pkg::AGE_W-1:0]    age_clock;
  logic [mva_pkg::NUM_CHANNELS-1:0] pedal_down;

  // voice memory and its valid bits
  mva_pkg::voice_t              mem [mva_pkg::NUM_VOICES];
  logic [mva_pkg::NUM_VOICES-1:0] mem_ok;
  mva_pkg::voice_t              rd_data;
  logic                         rd_ok;

  logic                         mem_re;
  logic [mva_pkg::VOICE_W-1:0]  rd_addr;
  logic                         mem_we;
  logic [mva_pkg::VOICE_W-1:0]  wr_addr;
  mva_pkg::voice_t              wr_data;

  mva_pkg::voice_t              entry;
  mva_pkg::voice_t              entry_next;
  logic                         match;
  logic                         is_note_on;
  logic                         do_alloc;
  logic                         scan_end;
  logic                         in_ch_ok;
  logic [mva_pkg::CH_IDX_W-1:0] in_ch_idx;
  logic                         in_pedal;
  logic [mva_pkg::AGE_W-1:0]    age_next;
  logic [mva_pkg::VOICE_W-1:0]  tgt_idx;
  logic [mva_pkg::CNT_W-1:0]    alloc_cnt;

  function automatic logic [4:0] sat_count(input logic [mva_pkg::CNT_W-1:0] n);
    logic [4:0] r;
    r = (32'(n) > 32'd31) ? 5'd31 : 5'(n);
    return r;
  endfunction

  assign busy      = (state != S_IDLE);
  assign in_ch_ok  = (cmd.channel >= 5'd1) && (32'(cmd.channel) <= mva_pkg::NUM_CHANNELS);
  assign in_ch_idx = mva_pkg::CH_IDX_W'(cmd.channel - 5'd1);
  assign in_pedal  = (32'(cmd.pedal_value) >= mva_pkg::PEDAL_THRESHOLD);

  assign is_note_on = (cmd_q.opcode == mva_pkg::OP_NOTE_ON);
  assign do_alloc   = is_note_on && ch_ok && cmd_q.sample_present;
  assign age_next   = (age_clock == '1) ? age_clock : age_clock + 1'b1;
  assign tgt_idx    = free_found ? free_idx : min_idx;
  assign alloc_cnt  = busy_cnt + mva_pkg::CNT_W'(free_found);

  assign mem_re   = (state == S_SCAN) && (32'(rd_cnt) < mva_pkg::NUM_VOICES);
  assign rd_addr  = rd_cnt[mva_pkg::VOICE_W-1:0];
  assign scan_end = (state == S_SCAN) && !mem_re && !proc_vld;

  assign entry = rd_ok ? rd_data : '0;
  assign match = entry.busy && (entry.channel == cmd_q.channel);

  // per-voice update for the event held in cmd_q
  always_comb begin
    entry_next = entry;
    if (cmd_q.opcode == mva_pkg::OP_VOICE_DONE) begin
      if (32'(proc_idx) == 32'(cmd_q.finished_voice)) entry_next = '0;
    end else if (ch_ok) begin
      case (cmd_q.opcode)
        mva_pkg::OP_NOTE_OFF: begin
          if (match && entry.note == cmd_q.note && entry.held) begin
            entry_next.held = 1'b0;
            if (!pedal_cur) entry_next.releasing = 1'b1;
          end
        end
        mva_pkg::OP_SUSTAIN: begin
          if (!pedal_cur && match && !entry.held) entry_next.releasing = 1'b1;
        end
        mva_pkg::OP_SOUND_OFF: begin
          if (match) entry_next = '0;
        end
        mva_pkg::OP_NOTES_OFF: begin
          if (match) begin
            entry_next.held      = 1'b0;
            entry_next.releasing = 1'b1;
          end
        end
        mva_pkg::OP_RESET_CTRL: begin
          if (match && !entry.held) entry_next.releasing = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // write port: scan write-back, or the new voice on commit
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = proc_idx;
    wr_data = entry_next;
    if (state == S_COMMIT) begin
      mem_we            = 1'b1;
      wr_addr           = tgt_idx;
      wr_data           = '0;
      wr_data.busy      = 1'b1;
      wr_data.note      = cmd_q.note;
      wr_data.channel   = cmd_q.channel;
      wr_data.held      = 1'b1;
      wr_data.age       = age_next;
    end else if (state == S_SCAN && proc_vld && !is_note_on) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (mem_we) mem_ok[wr_addr] <= 1'b1;
      if (mem_re) rd_ok <= mem_ok[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      result     <= '0;
      rd_cnt     <= '0;
      proc_vld   <= 1'b0;
      age_clock  <= '0;
      pedal_down <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            cmd_q      <= cmd;
            ch_ok      <= in_ch_ok;
            rd_cnt     <= '0;
            proc_vld   <= 1'b0;
            free_found <= 1'b0;
            busy_cnt   <= '0;
            if (in_ch_ok && cmd.opcode == mva_pkg::OP_SUSTAIN) begin
              pedal_down[in_ch_idx] <= in_pedal;
              pedal_cur             <= in_pedal;
            end else if (in_ch_ok && cmd.opcode == mva_pkg::OP_RESET_CTRL) begin
              pedal_down[in_ch_idx] <= 1'b0;
              pedal_cur             <= 1'b0;
            end else begin
              pedal_cur <= pedal_down[in_ch_idx];
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          proc_vld <= mem_re;
          proc_idx <= rd_addr;
          done     <= scan_end && !do_alloc;
          if (mem_re) rd_cnt <= rd_cnt + 1'b1;
          if (proc_vld) begin
            busy_cnt <= busy_cnt + mva_pkg::CNT_W'(entry_next.busy);
            if (!free_found && !entry.busy) begin
              free_found <= 1'b1;
              free_idx   <= proc_idx;
            end
            // strict less keeps the lowest index on equal ages
            if (proc_idx == '0 || entry.age < min_age) begin
              min_age <= entry.age;
              min_idx <= proc_idx;
            end
          end
          if (scan_end) begin
            if (do_alloc) begin
              state <= S_COMMIT;
            end else begin
              result <= '{allocated: 1'b0, voice_index: 4'd0, stole_voice: 1'b0,
                          active_count: sat_count(busy_cnt)};
              state  <= S_IDLE;
            end
          end
        end
        S_COMMIT: begin
          age_clock <= age_next;
          done      <= 1'b1;
          result    <= '{allocated: 1'b1, voice_index: 4'(tgt_idx),
                         stole_voice: !free_found, active_count: sat_count(alloc_cnt)};
          state     <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/mva_checker.sv -----
// mva_checker: watches the event and result channels of midi_voice_allocator,
// keeps its own voice table to predict every result beat and compares them
// depends on mva_pkg
module mva_checker
  import mva_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      errors,
  output int      pending,
  output int      steals,
  output int      reports
);

  voice_t           voices   [NUM_VOICES];
  logic             pedal_dn [NUM_CHANNELS];
  logic [AGE_W-1:0] age_stamp;
  result_t          event_reports [$];

  // updates the voice table for one event and returns the report it causes
  function automatic result_t apply_event(input cmd_t c);
    result_t r;
    int      ch;
    int      slot;
    int      live;
    bit      hit;
    r    = '0;
    ch   = int'(c.channel);
    slot = 0;
    hit  = 1'b0;
    live = 0;
    if (c.opcode == OP_VOICE_DONE) begin
      // channel is a don't care here
      if (int'(c.finished_voice) < NUM_VOICES) voices[c.finished_voice] = '0;
    end else if (ch >= 1 && ch <= NUM_CHANNELS) begin
      case (c.opcode)
        OP_NOTE_ON: begin
          if (c.sample_present) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (!hit && !voices[v].busy) begin
                slot = v;
                hit  = 1'b1;
              end
            end
            if (!hit) begin
              // oldest stamp wins, lowest index on a tie
              for (int v = 1; v < NUM_VOICES; v++) begin
                if (voices[v].age < voices[slot].age) slot = v;
              end
              r.stole_voice = voices[slot].busy;
            end
            if (age_stamp != '1) age_stamp = age_stamp + 1'b1;
            voices[slot]         = '0;
            voices[slot].busy    = 1'b1;
            voices[slot].note    = c.note;
            voices[slot].channel = c.channel;
            voices[slot].held    = 1'b1;
            voices[slot].age     = age_stamp;
            r.allocated          = 1'b1;
            r.voice_index        = 4'(slot);
          end
        end
        OP_NOTE_OFF: begin
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (voices[v].busy && voices[v].channel == c.channel &&
                voices[v].note == c.note && voices[v].held) begin
              voices[v].held = 1'b0;
              if (!pedal_dn[ch-1]) voices[v].releasing = 1'b1;
            end
          end
        end
        OP_SUSTAIN, OP_RESET_CTRL: begin
          pedal_dn[ch-1] = (c.opcode == OP_SUSTAIN) &&
                           (int'(c.pedal_value) >= PEDAL_THRESHOLD);
          if (!pedal_dn[ch-1]) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (voices[v].busy && voices[v].channel == c.channel && !voices[v].held)
                voices[v].releasing = 1'b1;
            end
          end
        end
        OP_SOUND_OFF: begin
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (voices[v].busy && voices[v].channel == c.channel) voices[v] = '0;
          end
        end
        OP_NOTES_OFF: begin
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (voices[v].busy && voices[v].channel == c.channel) begin
              voices[v].held      = 1'b0;
              voices[v].releasing = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    for (int v = 0; v < NUM_VOICES; v++) live += voices[v].busy ? 1 : 0;
    r.active_count = 5'(live > 31 ? 31 : live);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int v = 0; v < NUM_VOICES; v++) voices[v] = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) pedal_dn[k] = 1'b0;
      age_stamp = '0;
      event_reports.delete();
    end else begin
      // retire first: a new event may be taken at the edge its predecessor reports
      if (done) begin
        reports++;
        if (event_reports.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing outstanding: alloc=%0d idx=%0d stole=%0d active=%0d",
                   $time, result.allocated, result.voice_index, result.stole_voice,
                   result.active_count);
        end else begin
          want = event_reports.pop_front();
          if (result.allocated !== want.allocated || result.voice_index !== want.voice_index ||
              result.stole_voice !== want.stole_voice ||
              result.active_count !== want.active_count) begin
            errors++;
            $display("%0t: report mismatch, expected alloc=%0d idx=%0d stole=%0d active=%0d",
                     $time, want.allocated, want.voice_index, want.stole_voice,
                     want.active_count);
            $display("%0t:                  actual   alloc=%0d idx=%0d stole=%0d active=%0d",
                     $time, result.allocated, result.voice_index, result.stole_voice,
                     result.active_count);
          end
        end
      end
      if (start && !busy) begin
        want = apply_event(cmd);
        if (want.stole_voice) steals++;
        event_reports.push_back(want);
      end
    end
    pending = event_reports.size();
  end

endmodule

// ----- verif/tb_midi_voice_allocator.sv -----
// tb_midi_voice_allocator: drives directed and random MIDI events into the
// voice allocator with random sender gaps; mva_checker predicts and compares
// depends on mva_pkg, midi_voice_allocator and mva_checker
module tb_midi_voice_allocator;
  import mva_pkg::*;

  localparam logic [2:0]  OP_UNUSED   = 3'd7;
  localparam int          RANDOM_CNT  = 1200;
  localparam int          FLAT_OUT    = 200;   // tail of the run without gaps
  localparam int          DRAIN_WAIT  = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  int errors;
  int pending;
  int steals;
  int reports;

  int unsigned cycle_count = 0;
  int          ops_sent [8];
  int          bad_channel;
  bit          gaps_on;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  midi_voice_allocator i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  mva_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending),
    .steals  (steals),
    .reports (reports)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d reports outstanding", cycle_count, pending);
    $display("Some tests failed");
    $finish;
  end

  function automatic cmd_t make_event(input logic [2:0] op, input int ch, input int nt,
                                      input bit sp, input int pedal, input int fin);
    cmd_t c;
    c.opcode         = op;
    c.channel        = 5'(ch);
    c.note           = 7'(nt);
    c.sample_present = sp;
    c.pedal_value    = 7'(pedal);
    c.finished_voice = 4'(fin);
    return c;
  endfunction

  // mostly well-formed traffic on a few channels and a small note pool,
  // with unused fields left random
  function automatic cmd_t random_event();
    cmd_t c;
    int   pick;
    c    = cmd_t'(27'($urandom));
    pick = $urandom_range(0, 99);
    c.channel = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 16))
                                            : 5'($urandom_range(1, 4));
    if ($urandom_range(0, 1)) c.note = 7'($urandom_range(60, 67));
    if (pick < 45) begin
      c.opcode         = OP_NOTE_ON;
      c.sample_present = ($urandom_range(0, 9) != 0);
    end else if (pick < 65) begin
      c.opcode = OP_NOTE_OFF;
    end else if (pick < 75) begin
      c.opcode = OP_SUSTAIN;
    end else if (pick < 85) begin
      c.opcode  = OP_VOICE_DONE;
      c.channel = 5'($urandom);
    end else if (pick < 88) begin
      c.opcode = OP_SOUND_OFF;
    end else if (pick < 91) begin
      c.opcode = OP_NOTES_OFF;
    end else if (pick < 94) begin
      c.opcode = OP_RESET_CTRL;
    end else if (pick < 97) begin
      c.opcode  = 3'($urandom_range(0, 5));
      c.channel = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    end else begin
      c.opcode = OP_UNUSED;
    end
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_event(input cmd_t c);
    int gap;
    while (busy) @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    // busy is low here, so the next rising edge takes the beat
    start <= 1'b1;
    cmd   <= c;
    @(negedge clk);
    start <= 1'b0;
    ops_sent[c.opcode]++;
    if (c.opcode != OP_VOICE_DONE && (c.channel == 5'd0 || c.channel > 5'd16))
      bad_channel++;
  endtask

  initial begin
    cmd_t directed [$];
    rst     = 1'b1;
    start   = 1'b0;
    cmd     = '0;
    gaps_on = 1'b1;
    bad_channel = 0;
    foreach (ops_sent[k]) ops_sent[k] = 0;

    // field extremes, no-sample, bad channels, pedal hold and release,
    // channel clears, freeing a free voice, unused opcode
    directed.push_back(make_event(OP_NOTE_ON,    1,   0, 1,   0,  0));
    directed.push_back(make_event(OP_NOTE_ON,   16, 127, 1, 127, 15));
    directed.push_back(make_event(OP_NOTE_ON,    5,  60, 0,   0,  0));
    directed.push_back(make_event(OP_NOTE_ON,    0,  61, 1,   0,  0));
    directed.push_back(make_event(OP_NOTE_ON,   17,  62, 1,   0,  0));
    directed.push_back(make_event(OP_NOTE_ON,   31,  63, 1,   0,  0));
    directed.push_back(make_event(OP_SUSTAIN,   16,   0, 0, 127,  0));
    directed.push_back(make_event(OP_NOTE_OFF,  16, 127, 0,   0,  0));
    directed.push_back(make_event(OP_SUSTAIN,   16,   0, 0,  63,  0));
    directed.push_back(make_event(OP_NOTE_OFF,   1,   0, 0,   0,  0));
    directed.push_back(make_event(OP_SUSTAIN,    1,   0, 0,  64,  0));
    directed.push_back(make_event(OP_NOTE_ON,    1,  64, 1,   0,  0));
    directed.push_back(make_event(OP_NOTES_OFF,  1,   0, 0,   0,  0));
    directed.push_back(make_event(OP_RESET_CTRL, 1,   0, 0,   0,  0));
    directed.push_back(make_event(OP_SUSTAIN,    0,   0, 0, 127,  0));
    directed.push_back(make_event(OP_SOUND_OFF, 16,   0, 0,   0,  0));
    directed.push_back(make_event(OP_VOICE_DONE, 0,   0, 0,   0,  0));
    directed.push_back(make_event(OP_VOICE_DONE, 31,  0, 0,   0, 15));
    directed.push_back(make_event(OP_UNUSED,     3,  70, 1, 100,  2));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[k]) send_event(directed[k]);
    for (int k = 0; k < RANDOM_CNT; k++) begin
      if (k >= RANDOM_CNT - FLAT_OUT) gaps_on = 1'b0;
      else if (k % 50 == 0) gaps_on = $urandom_range(0, 2) != 0;
      send_event(random_event());
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d note on, %0d note off, %0d pedal, %0d channel clears, %0d voice frees",
             ops_sent[OP_NOTE_ON], ops_sent[OP_NOTE_OFF], ops_sent[OP_SUSTAIN],
             ops_sent[OP_SOUND_OFF] + ops_sent[OP_NOTES_OFF] + ops_sent[OP_RESET_CTRL],
             ops_sent[OP_VOICE_DONE]);
    $display("plus %0d bad channel and %0d unused opcode events; %0d reports, %0d steals",
             bad_channel, ops_sent[OP_UNUSED], reports, steals);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
